// ===== hdl/slmu_pkg.sv =====
// Shared types, constants and fixed-point helpers for the sparse momentum update block.
package slmu_pkg;

  localparam int FEATURES    = 4096;
  localparam int TOUCH_DEPTH = 1024;
  localparam int IDX_W       = $clog2(FEATURES);
  localparam int TL_AW       = $clog2(TOUCH_DEPTH);
  localparam int CNT_W       = $clog2(TOUCH_DEPTH + 1);
  localparam int BL_W        = 11;
  localparam int MAG_W       = 38;
  localparam int DIV_CW      = $clog2(MAG_W + 1);

  localparam logic [2:0] KIND_SAMPLE  = 3'd0;
  localparam logic [2:0] KIND_FEATURE = 3'd1;
  localparam logic [2:0] KIND_BATCH   = 3'd2;
  localparam logic [2:0] KIND_READ    = 3'd3;
  localparam logic [2:0] KIND_WRITE   = 3'd4;

  localparam logic [1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [1:0] CFG_MOMENTUM   = 2'd1;
  localparam logic [1:0] CFG_L2         = 2'd2;

  typedef enum logic [2:0] {
    OP_SAMPLE,
    OP_FEATURE,
    OP_BATCH,
    OP_READ,
    OP_WRITE,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [30:0] learn_rate;
    logic [24:0] momentum_decay;
    logic [30:0] l2_strength;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic               idx_ok;
    logic signed [31:0] val;
    logic               label;
    logic [24:0]        score;
    logic [BL_W-1:0]    bl;
  } item_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } back_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    if (v > 41'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -41'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // Saturated signed value of a quotient magnitude with its sign.
  function automatic logic signed [31:0] term_sat(input logic [MAG_W-1:0] q, input logic neg);
    if (q >= MAG_W'(64'h80000000)) return neg ? 32'sh80000000 : 32'sh7FFFFFFF;
    else return neg ? -$signed(q[31:0]) : $signed(q[31:0]);
  endfunction

  // Q8.24 product scaled back, truncating toward zero.
  function automatic logic signed [39:0] trunc_q(input logic signed [63:0] p);
    logic signed [63:0] adj;
    adj = p + $signed({40'd0, {24{p[63]}}});
    return adj[63:24];
  endfunction

endpackage

// ===== hdl/slmu_ifs.sv =====
// Handshake channel interfaces for the input, configuration and result sides.
interface slmu_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [11:0]        feature_index;
  logic signed [31:0] feature_value;
  logic               label;
  logic [24:0]        score;
  logic [10:0]        batch_len;
  modport source(output valid, kind, feature_index, feature_value, label, score, batch_len,
                 input ready);
  modport sink(input valid, kind, feature_index, feature_value, label, score, batch_len,
               output ready);
endinterface

interface slmu_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

interface slmu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] weight_value;
  logic [10:0]        updated_count;
  logic               status;
  modport source(output valid, weight_value, updated_count, status, input ready);
  modport sink(input valid, weight_value, updated_count, status, output ready);
endinterface

// ===== hdl/sparse_lr_momentum_update_unit.sv =====
// Top level of the sparse logistic-regression momentum update block.
//
//  channel  | direction | transaction carries
//  in_ch    | in        | kind, feature_index, feature_value, label, score, batch_len
//  cfg_ch   | in        | register index and write data, always ready
//  out_ch   | out       | weight_value, updated_count, status, one per input item
//
// Each gradient term goes through the divider unless batch_len is one.
// Batch end updates each touched entry and then clears their gradients, or sweeps
// the whole gradient store when the touched list overflowed.
// After reset a pass clears the stores; in_ch is not ready meanwhile.
// A two-entry queue and the output register let either side stall independently.
module sparse_lr_momentum_update_unit (
  input logic        clk,
  input logic        rst_n,
  slmu_in_if.sink    in_ch,
  slmu_cfg_if.sink   cfg_ch,
  slmu_out_if.source out_ch
);
  import slmu_pkg::*;

  cfg_t      cfg_r;
  item_t     head;
  logic      head_valid;
  back_ctl_t ctl;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.learn_rate     <= 31'd167772;
      cfg_r.momentum_decay <= 25'd15099494;
      cfg_r.l2_strength    <= 31'd0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_LEARN_RATE: cfg_r.learn_rate     <= cfg_ch.data[30:0];
        CFG_MOMENTUM:   cfg_r.momentum_decay <= cfg_ch.data[24:0];
        CFG_L2:         cfg_r.l2_strength    <= cfg_ch.data[30:0];
        default: ;
      endcase
    end
  end

  slmu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .ctl        (ctl),
    .head_valid (head_valid),
    .head       (head)
  );

  slmu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head),
    .ctl        (ctl),
    .out_ch     (out_ch)
  );

endmodule

// ===== hdl/slmu_front.sv =====
// Front end: decodes incoming transactions and holds them in a two-entry queue.
module slmu_front (
  input  logic                clk,
  input  logic                rst_n,
  slmu_in_if.sink             in_ch,
  input  slmu_pkg::back_ctl_t ctl,
  output logic                head_valid,
  output slmu_pkg::item_t     head
);
  import slmu_pkg::*;

  item_t      q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  item_t      cls;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2) && !ctl.busy;
  assign push        = in_ch.valid && in_ch.ready;
  assign head_valid  = (cnt_r != 2'd0);
  assign head        = q_r[rp_r];

  always_comb begin
    unique case (in_ch.kind)
      KIND_SAMPLE:  cls.op = OP_SAMPLE;
      KIND_FEATURE: cls.op = OP_FEATURE;
      KIND_BATCH:   cls.op = OP_BATCH;
      KIND_READ:    cls.op = OP_READ;
      KIND_WRITE:   cls.op = OP_WRITE;
      default:      cls.op = OP_NONE;
    endcase
    cls.idx    = in_ch.feature_index[IDX_W-1:0];
    cls.idx_ok = 32'(in_ch.feature_index) < FEATURES;
    cls.val    = in_ch.feature_value;
    cls.label  = in_ch.label;
    cls.score  = in_ch.score;
    // A batch length of zero behaves as one.
    cls.bl     = (in_ch.batch_len == '0) ? BL_W'(1) : in_ch.batch_len;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (ctl.pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(ctl.pop);
    end
  end

endmodule

// ===== hdl/slmu_div.sv =====
// Restoring divider, one quotient bit per cycle.
module slmu_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [slmu_pkg::MAG_W-1:0]  dividend,
  input  logic [slmu_pkg::BL_W-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic [slmu_pkg::MAG_W-1:0]  quotient
);
  import slmu_pkg::*;

  logic [BL_W-1:0]   rem_r;
  logic [BL_W-1:0]   den_r;
  logic [MAG_W-1:0]  quo_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [BL_W:0]     trial;
  logic [BL_W:0]     diff;
  logic              ge;

  assign trial    = {rem_r, quo_r[MAG_W-1]};
  assign ge       = trial >= {1'b0, den_r};
  assign diff     = trial - {1'b0, den_r};
  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[BL_W-1:0] : trial[BL_W-1:0];
      quo_r <= {quo_r[MAG_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(MAG_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/slmu_back.sv =====
// Back end: weight, velocity and gradient stores, gradient accumulation and batch update.
module slmu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slmu_pkg::cfg_t       cfg,
  input  logic                 head_valid,
  input  slmu_pkg::item_t      head,
  output slmu_pkg::back_ctl_t  ctl,
  slmu_out_if.source           out_ch
);
  import slmu_pkg::*;

  typedef enum logic [19:0] {
    ST_INIT  = 20'h00001,
    ST_IDLE  = 20'h00002,
    ST_FETCH = 20'h00004,
    ST_MUL   = 20'h00008,
    ST_MAG   = 20'h00010,
    ST_QSEL  = 20'h00020,
    ST_DIV   = 20'h00040,
    ST_ACC   = 20'h00080,
    ST_STORE = 20'h00100,
    ST_TL    = 20'h00200,
    ST_TLW   = 20'h00400,
    ST_MRD   = 20'h00800,
    ST_MOM   = 20'h01000,
    ST_MOM2  = 20'h02000,
    ST_UPD   = 20'h04000,
    ST_WWR   = 20'h08000,
    ST_LCR   = 20'h10000,
    ST_LCW   = 20'h20000,
    ST_GCLR  = 20'h40000,
    ST_OUT   = 20'h80000
  } state_t;

  localparam logic [IDX_W-1:0] BIAS = IDX_W'(FEATURES - 1);

  logic signed [31:0] w_mem  [FEATURES];
  logic signed [31:0] v_mem  [FEATURES];
  logic [32:0]        gs_mem [FEATURES];
  logic [IDX_W-1:0]   tl_mem [TOUCH_DEPTH];

  logic signed [31:0] w_rd, v_rd;
  logic [32:0]        gs_rd;
  logic [IDX_W-1:0]   tl_rd;

  state_t             state_r;
  item_t              cur_r;
  logic [IDX_W-1:0]   addr_r;
  logic signed [25:0] residual_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               ovf_r;
  logic signed [31:0] g_r, w_r, vel_r;
  logic               seen_r;
  logic               l2ph_r;
  logic               bias_r;
  logic signed [63:0] prod_r, pa_r;
  logic [MAG_W-1:0]   mag_r, q_r;
  logic               neg_r;
  logic [CNT_W-1:0]   wi_r;
  logic [IDX_W-1:0]   ci_r;
  logic signed [31:0] res_w_r;

  logic               out_v_r;
  logic signed [31:0] out_w_r;
  logic [10:0]        out_c_r;
  logic               out_s_r;
  logic               out_load;

  logic [IDX_W-1:0]   rd_addr;
  logic               w_we, v_we, gs_we, tl_we;
  logic [IDX_W-1:0]   w_wa, gs_wa;
  logic signed [31:0] w_wd;
  logic [32:0]        gs_wd;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p, p_abs;
  logic signed [25:0] res_new, res_abs;
  logic signed [31:0] grad_new, w_new;
  logic               div_start, div_busy, div_done;
  logic [MAG_W-1:0]   div_q;
  logic               list_room;

  slmu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_r),
    .divisor  (cur_r.bl),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign res_new   = $signed({1'b0, head.label, 24'd0}) - $signed({1'b0, head.score});
  assign res_abs   = residual_r[25] ? -residual_r : residual_r;
  assign p_abs     = prod_r[63] ? -prod_r : prod_r;
  assign mul_p     = mul_a * mul_b;
  assign grad_new  = sat32(41'(g_r) + 41'(term_sat(q_r, neg_r)));
  assign w_new     = sat32(41'(w_rd) + 41'(vel_r));
  assign list_room = cnt_r < CNT_W'(TOUCH_DEPTH);
  assign div_start = (state_r == ST_QSEL) && (cur_r.bl != BL_W'(1));
  assign ctl.pop   = (state_r == ST_IDLE) && head_valid;
  assign ctl.busy  = (state_r == ST_INIT);
  assign out_load  = (state_r == ST_OUT) && (!out_v_r || out_ch.ready);

  assign out_ch.valid         = out_v_r;
  assign out_ch.weight_value  = out_w_r;
  assign out_ch.updated_count = out_c_r;
  assign out_ch.status        = out_s_r;

  always_comb begin
    if (state_r == ST_IDLE) begin
      rd_addr = (head.op == OP_SAMPLE || head.op == OP_BATCH) ? BIAS : head.idx;
    end else begin
      rd_addr = addr_r;
    end
  end

  // One shared multiplier; operands depend on the step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MUL: begin
        mul_a = l2ph_r ? $signed({1'b0, cfg.l2_strength}) : 32'(residual_r);
        mul_b = l2ph_r ? w_r : cur_r.val;
      end
      ST_MOM: begin
        mul_a = $signed({7'd0, cfg.momentum_decay});
        mul_b = v_rd;
      end
      ST_MOM2: begin
        mul_a = $signed({1'b0, cfg.learn_rate});
        mul_b = $signed(gs_rd[31:0]);
      end
      default: ;
    endcase
  end

  always_comb begin
    w_we  = 1'b0;
    v_we  = 1'b0;
    gs_we = 1'b0;
    w_wa  = addr_r;
    w_wd  = '0;
    gs_wa = addr_r;
    gs_wd = '0;
    unique case (state_r)
      ST_INIT: begin
        w_we  = 1'b1;
        v_we  = 1'b1;
        gs_we = 1'b1;
        w_wa  = ci_r;
        gs_wa = ci_r;
      end
      ST_IDLE: begin
        w_we = head_valid && (head.op == OP_WRITE) && head.idx_ok;
        w_wa = head.idx;
        w_wd = head.val;
      end
      ST_STORE: begin
        gs_we = 1'b1;
        gs_wd = {seen_r, g_r};
      end
      ST_WWR: begin
        w_we = 1'b1;
        v_we = 1'b1;
        w_wd = w_new;
      end
      ST_LCR: begin
        gs_we = (wi_r == cnt_r);
        gs_wa = BIAS;
      end
      ST_LCW: begin
        gs_we = 1'b1;
        gs_wa = tl_rd;
      end
      ST_GCLR: begin
        gs_we = 1'b1;
        gs_wa = ci_r;
      end
      default: ;
    endcase
  end

  assign tl_we = (state_r == ST_ACC) && (cur_r.op == OP_FEATURE) && l2ph_r && list_room;

  always_ff @(posedge clk) begin
    if (w_we) w_mem[w_wa] <= w_wd;
    if (v_we) v_mem[w_wa] <= (state_r == ST_INIT) ? 32'sd0 : vel_r;
    if (gs_we) gs_mem[gs_wa] <= gs_wd;
    if (tl_we) tl_mem[cnt_r[TL_AW-1:0]] <= addr_r;
    w_rd  <= w_mem[rd_addr];
    v_rd  <= v_mem[rd_addr];
    gs_rd <= gs_mem[rd_addr];
    tl_rd <= tl_mem[wi_r[TL_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      ci_r       <= '0;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      residual_r <= '0;
      out_v_r    <= 1'b0;
      wi_r       <= '0;
      bias_r     <= 1'b0;
      l2ph_r     <= 1'b0;
    end else begin
      if (out_load) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;

      unique case (state_r)
        ST_INIT: begin
          ci_r <= ci_r + 1'b1;
          if (ci_r == BIAS) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (head_valid) begin
            cur_r   <= head;
            addr_r  <= rd_addr;
            res_w_r <= '0;
            l2ph_r  <= (head.op == OP_BATCH);
            bias_r  <= 1'b0;
            unique case (head.op)
              OP_SAMPLE: begin
                residual_r <= res_new;
                state_r    <= ST_FETCH;
              end
              OP_FEATURE: state_r <= head.idx_ok ? ST_FETCH : ST_OUT;
              OP_BATCH, OP_READ: state_r <= ST_FETCH;
              default: state_r <= ST_OUT;
            endcase
          end
        end
        ST_FETCH: begin
          w_r    <= w_rd;
          g_r    <= $signed(gs_rd[31:0]);
          seen_r <= gs_rd[32];
          unique case (cur_r.op)
            OP_READ: begin
              res_w_r <= cur_r.idx_ok ? w_rd : 32'sd0;
              state_r <= ST_OUT;
            end
            OP_SAMPLE: begin
              mag_r   <= MAG_W'(unsigned'(res_abs));
              neg_r   <= residual_r[25];
              state_r <= ST_QSEL;
            end
            default: state_r <= ST_MUL;
          endcase
        end
        ST_MUL: begin
          prod_r  <= mul_p;
          state_r <= ST_MAG;
        end
        ST_MAG: begin
          // The L2 term enters with the opposite sign of its product.
          mag_r   <= p_abs[61:24];
          neg_r   <= prod_r[63] ^ l2ph_r;
          state_r <= ST_QSEL;
        end
        ST_QSEL: begin
          if (cur_r.bl == BL_W'(1)) begin
            q_r     <= mag_r;
            state_r <= ST_ACC;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            q_r     <= div_q;
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          g_r     <= grad_new;
          state_r <= ST_STORE;
          if (cur_r.op == OP_FEATURE) begin
            if (!l2ph_r) begin
              if (cur_r.bl == BL_W'(1) || !seen_r) begin
                l2ph_r  <= 1'b1;
                state_r <= ST_MUL;
              end
            end else begin
              if (cur_r.bl != BL_W'(1)) seen_r <= 1'b1;
              if (list_room) cnt_r <= cnt_r + 1'b1;
              else ovf_r <= 1'b1;
            end
          end
        end
        ST_STORE: begin
          if (cur_r.op == OP_BATCH) begin
            wi_r <= '0;
            if (cnt_r == '0) begin
              addr_r  <= BIAS;
              bias_r  <= 1'b1;
              state_r <= ST_MRD;
            end else begin
              state_r <= ST_TL;
            end
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_TL:   state_r <= ST_TLW;
        ST_TLW: begin
          addr_r  <= tl_rd;
          state_r <= ST_MRD;
        end
        ST_MRD:  state_r <= ST_MOM;
        ST_MOM: begin
          pa_r    <= mul_p;
          state_r <= ST_MOM2;
        end
        ST_MOM2: begin
          prod_r  <= mul_p;
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          vel_r   <= sat32(41'(trunc_q(pa_r)) + 41'(trunc_q(prod_r)));
          state_r <= ST_WWR;
        end
        ST_WWR: begin
          if (!bias_r) begin
            wi_r <= wi_r + 1'b1;
            if (wi_r + 1'b1 == cnt_r) begin
              addr_r  <= BIAS;
              bias_r  <= 1'b1;
              state_r <= ST_MRD;
            end else begin
              state_r <= ST_TL;
            end
          end else if (ovf_r) begin
            // Some gradients are not on the list, so sweep the whole store.
            ci_r    <= '0;
            state_r <= ST_GCLR;
          end else begin
            wi_r    <= '0;
            state_r <= ST_LCR;
          end
        end
        ST_LCR: begin
          state_r <= (wi_r == cnt_r) ? ST_OUT : ST_LCW;
        end
        ST_LCW: begin
          wi_r    <= wi_r + 1'b1;
          state_r <= ST_LCR;
        end
        ST_GCLR: begin
          ci_r <= ci_r + 1'b1;
          if (ci_r == BIAS) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_w_r <= res_w_r;
            out_c_r <= (cur_r.op == OP_BATCH) ? 11'(32'(cnt_r) + 1) : 11'd0;
            out_s_r <= ovf_r;
            if (cur_r.op == OP_BATCH) begin
              cnt_r <= '0;
              ovf_r <= 1'b0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_INIT;
      endcase
    end
  end

  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TOUCH_DEPTH))
    else $error("touched count exceeds list depth");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && cur_r.op == OP_BATCH) |=> (cnt_r == '0 && !ovf_r))
    else $error("batch end left list count or overflow set");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |=> state_r != ST_IDLE)
    else $error("item popped without being processed");

endmodule

// ===== tb/sv/tb_sparse_lr_momentum_update_unit.sv =====
// Self-checking testbench for the sparse logistic-regression momentum update unit.
module tb_sparse_lr_momentum_update_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import slmu_pkg::*;

  localparam logic [2:0] KIND_SPARE5 = 3'd5;
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;
  localparam logic [1:0] CFG_SPARE   = 2'd3;
  localparam int  BIAS_IDX  = FEATURES - 1;
  localparam longint Q_ONE  = 64'sd16777216;
  localparam int  CYCLE_LIMIT = 1500000;
  localparam int  N_DIR = 24;

  typedef struct packed {
    logic [2:0]         kind;
    logic [11:0]        idx;
    logic signed [31:0] val;
    logic               label;
    logic [24:0]        score;
    logic [10:0]        bl;
  } txn_t;

  typedef struct packed {
    logic signed [31:0] weight;
    logic [10:0]        count;
    logic               status;
  } resp_t;

  typedef struct packed {
    txn_t  t;
    logic  typed;
    resp_t r;
  } dir_row_t;

  logic clk;
  logic rst_n;
  slmu_in_if  in_ch();
  slmu_cfg_if cfg_ch();
  slmu_out_if out_ch();

  sparse_lr_momentum_update_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg_ch(cfg_ch), .out_ch(out_ch)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Shadow copy of the unit's training state.
  logic [30:0] alpha;
  logic [24:0] beta;
  logic [30:0] lambda;
  int          wgt [FEATURES];
  int          vel [FEATURES];
  int          grad [FEATURES];
  bit          seen [FEATURES];
  int          touched [TOUCH_DEPTH];
  int          n_touched;
  int          residual;
  bit          ovf;

  resp_t awaited_responses[$];
  int    mismatches, items_sent, results_checked, batches_closed, ovf_reports;
  int    cycles;
  bit    tx_gaps_on, rx_stall_on, hold_req;

  function automatic int clamp_s32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic void grad_acc(int i, longint term);
    grad[i] = clamp_s32(longint'(grad[i]) + longint'(clamp_s32(term)));
  endfunction

  function automatic longint decay_term(int i, longint bl);
    longint p;
    p = longint'(lambda) * longint'(wgt[i]);
    return -(p / (bl * Q_ONE));
  endfunction

  function automatic void record_touch(int i);
    if (n_touched < TOUCH_DEPTH) begin
      touched[n_touched] = i;
      n_touched++;
    end else begin
      ovf = 1'b1;
    end
  endfunction

  function automatic void momentum_update(int i);
    longint a, b;
    a = (longint'(beta) * longint'(vel[i])) / Q_ONE;
    b = (longint'(alpha) * longint'(grad[i])) / Q_ONE;
    vel[i] = clamp_s32(a + b);
    wgt[i] = clamp_s32(longint'(wgt[i]) + longint'(vel[i]));
  endfunction

  function automatic resp_t train_step(txn_t t);
    resp_t  r;
    longint bl, res, p;
    int     i;
    r = '0;
    bl = longint'(t.bl);
    if (bl == 0) bl = 1;
    i = int'(t.idx);
    case (t.kind)
      KIND_SAMPLE: begin
        res = (t.label ? Q_ONE : 64'sd0) - longint'(t.score);
        residual = int'(res);
        grad_acc(BIAS_IDX, res / bl);
      end
      KIND_FEATURE: begin
        p = longint'(residual) * longint'(t.val);
        grad_acc(i, p / (bl * Q_ONE));
        if (bl == 1) begin
          grad_acc(i, decay_term(i, bl));
          record_touch(i);
        end else if (!seen[i]) begin
          grad_acc(i, decay_term(i, bl));
          seen[i] = 1'b1;
          record_touch(i);
        end
      end
      KIND_BATCH: begin
        grad_acc(BIAS_IDX, decay_term(BIAS_IDX, bl));
        for (int k = 0; k < n_touched; k++) momentum_update(touched[k]);
        momentum_update(BIAS_IDX);
        r.count = 11'(n_touched + 1);
        r.status = ovf;
        for (int k = 0; k < FEATURES; k++) begin
          grad[k] = 0;
          seen[k] = 1'b0;
        end
        n_touched = 0;
        ovf = 1'b0;
        return r;
      end
      KIND_READ: r.weight = wgt[i];
      KIND_WRITE: wgt[i] = int'(t.val);
      default: ;
    endcase
    r.status = ovf;
    return r;
  endfunction

  // Directed rows; a typed response is one that can be stated outright.
  dir_row_t dir_rows [0:N_DIR-1] = '{
    '{'{KIND_READ,    12'd0,    32'sd0,          1'b0, 25'd0,        11'd1},    1'b1, '0},
    '{'{KIND_WRITE,   12'd0,    32'sh7FFFFFFF,   1'b0, 25'd0,        11'd1},    1'b1, '0},
    '{'{KIND_READ,    12'd0,    32'sd0,          1'b0, 25'd0,        11'd1},    1'b1,
      '{32'sh7FFFFFFF, 11'd0, 1'b0}},
    '{'{KIND_WRITE,   12'd4095, 32'sh80000000,   1'b0, 25'd0,        11'd1},    1'b1, '0},
    '{'{KIND_READ,    12'd4095, 32'sd0,          1'b0, 25'd0,        11'd1},    1'b1,
      '{32'sh80000000, 11'd0, 1'b0}},
    '{'{KIND_WRITE,   12'd100,  -32'sd1,         1'b0, 25'd0,        11'd1},    1'b1, '0},
    '{'{KIND_READ,    12'd100,  32'sd0,          1'b0, 25'd0,        11'd1},    1'b1,
      '{-32'sd1, 11'd0, 1'b0}},
    '{'{KIND_SAMPLE,  12'd0,    32'sd0,          1'b1, 25'd0,        11'd1},    1'b0, '0},
    '{'{KIND_FEATURE, 12'd100,  32'sh7FFFFFFF,   1'b0, 25'd0,        11'd1},    1'b0, '0},
    '{'{KIND_FEATURE, 12'd100,  32'sh80000000,   1'b0, 25'd0,        11'd1},    1'b0, '0},
    '{'{KIND_FEATURE, 12'd0,    32'sh01000000,   1'b0, 25'd0,        11'd1},    1'b0, '0},
    '{'{KIND_BATCH,   12'd0,    32'sd0,          1'b0, 25'd0,        11'd1},    1'b0, '0},
    '{'{KIND_READ,    12'd100,  32'sd0,          1'b0, 25'd0,        11'd1},    1'b0, '0},
    '{'{KIND_SAMPLE,  12'd0,    32'sd0,          1'b0, 25'h1FFFFFF,  11'd0},    1'b0, '0},
    '{'{KIND_FEATURE, 12'd4095, 32'sh12345678,   1'b0, 25'd0,        11'd0},    1'b0, '0},
    '{'{KIND_SAMPLE,  12'd0,    32'sd0,          1'b1, 25'd16777216, 11'd2047}, 1'b0, '0},
    '{'{KIND_FEATURE, 12'd200,  32'sh80000000,   1'b0, 25'd0,        11'd2047}, 1'b0, '0},
    '{'{KIND_FEATURE, 12'd200,  32'sh7FFFFFFF,   1'b0, 25'd0,        11'd2047}, 1'b0, '0},
    '{'{KIND_BATCH,   12'd0,    32'sd0,          1'b0, 25'd0,        11'd2047}, 1'b0, '0},
    '{'{KIND_READ,    12'd200,  32'sd0,          1'b0, 25'd0,        11'd1},    1'b0, '0},
    '{'{KIND_READ,    12'd4095, 32'sd0,          1'b0, 25'd0,        11'd1},    1'b0, '0},
    '{'{KIND_SPARE5,  12'd0,    32'sd0,          1'b0, 25'd0,        11'd1},    1'b1, '0},
    '{'{KIND_SPARE6,  12'hFFF,  -32'sd1,         1'b1, 25'h1FFFFFF,  11'h7FF},  1'b1, '0},
    '{'{KIND_SPARE7,  12'd0,    32'sd0,          1'b0, 25'd0,        11'd1},    1'b1, '0}
  };

  task automatic send_txn(input txn_t t, input bit typed, input resp_t typed_r);
    int    gap;
    resp_t r;
    gap = tx_gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= t.kind;
    in_ch.feature_index <= t.idx;
    in_ch.feature_value <= t.val;
    in_ch.label         <= t.label;
    in_ch.score         <= t.score;
    in_ch.batch_len     <= t.bl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = train_step(t);
    awaited_responses.insert(awaited_responses.size(), typed ? typed_r : r);
    items_sent++;
  endtask

  task automatic send_pred(input txn_t t);
    send_txn(t, 1'b0, '0);
  endtask

  // Drain everything outstanding, then give the unit time to settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_LEARN_RATE: alpha  = data[30:0];
      CFG_MOMENTUM:   beta   = data[24:0];
      CFG_L2:         lambda = data[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] a, input logic [31:0] b, input logic [31:0] l);
    write_reg(CFG_LEARN_RATE, a);
    write_reg(CFG_MOMENTUM, b);
    write_reg(CFG_L2, l);
  endtask

  function automatic logic [11:0] pick_index();
    case ($urandom_range(0, 5))
      0:       return 12'($urandom_range(0, 4095));
      1:       return 12'(BIAS_IDX);
      default: return 12'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return $signed(32'($urandom_range(0, 32'h03FFFFFF))) - 32'sh02000000;
  endfunction

  function automatic txn_t noise_txn();
    txn_t t;
    t.kind  = 3'($urandom_range(0, 7));
    t.idx   = pick_index();
    t.val   = $urandom;
    t.label = 1'($urandom);
    t.score = 25'($urandom);
    t.bl    = 11'($urandom_range(0, 4) == 0 ? $urandom_range(0, 2047) : $urandom_range(1, 4));
    return t;
  endfunction

  // One training batch with random content, salted with stray transactions.
  task automatic random_batch();
    txn_t       t;
    logic [10:0] bl;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: bl = 11'd1;
      4:          bl = 11'd0;
      5:          bl = $urandom_range(0, 1) ? 11'd2047 : 11'($urandom_range(9, 2047));
      default:    bl = 11'($urandom_range(2, 8));
    endcase
    tx_gaps_on  = $urandom_range(0, 3) != 0;
    rx_stall_on = $urandom_range(0, 3) != 0;
    repeat ($urandom_range(1, 3)) begin
      t = '0;
      t.kind  = KIND_SAMPLE;
      t.label = 1'($urandom);
      t.score = $urandom_range(0, 9) == 0 ? 25'h1FFFFFF : 25'($urandom_range(0, 16777216));
      t.bl    = bl;
      t.idx   = 12'($urandom);
      send_pred(t);
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 7) == 0) send_pred(noise_txn());
        t = '0;
        t.kind = KIND_FEATURE;
        t.idx  = pick_index();
        t.val  = pick_value();
        t.bl   = bl;
        send_pred(t);
      end
    end
    t = '0;
    t.kind = KIND_BATCH;
    t.bl   = bl;
    send_pred(t);
    batches_closed++;
    repeat ($urandom_range(1, 3)) begin
      t = '0;
      t.idx  = pick_index();
      t.kind = $urandom_range(0, 4) == 0 ? KIND_WRITE : KIND_READ;
      t.val  = pick_value();
      send_pred(t);
    end
  endtask

  task automatic random_phase(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) random_batch();
  endtask

  // Enough features in a single-sample batch to run the touched list past its end.
  task automatic overflow_batch();
    txn_t t;
    tx_gaps_on = 1'b0;
    rx_stall_on = 1'b0;
    t = '0;
    t.kind  = KIND_SAMPLE;
    t.label = 1'b1;
    t.score = 25'($urandom_range(0, 16777216));
    t.bl    = 11'd1;
    send_pred(t);
    repeat (TOUCH_DEPTH + 6) begin
      t = '0;
      t.kind = KIND_FEATURE;
      t.idx  = 12'($urandom_range(0, 63));
      t.val  = pick_value();
      t.bl   = 11'd1;
      send_pred(t);
    end
    t = '0;
    t.kind = KIND_BATCH;
    t.bl   = 11'd1;
    send_pred(t);
    batches_closed++;
  endtask

  // Result side: per-transaction stall, plus one long hold-off on request.
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      n = rx_stall_on ? $urandom_range(0, 19) : 0;
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: weight %0d count %0d status %0d",
                   out_ch.weight_value, out_ch.updated_count, out_ch.status);
      end else begin
        resp_t e;
        e = awaited_responses.pop_front();
        results_checked++;
        if (out_ch.status && out_ch.updated_count != 0) ovf_reports++;
        if (out_ch.weight_value !== e.weight || out_ch.updated_count !== e.count ||
            out_ch.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on result %0d: exp w %0d cnt %0d st %0d, got w %0d cnt %0d st %0d",
                     results_checked, e.weight, e.count, e.status, out_ch.weight_value,
                     out_ch.updated_count, out_ch.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycles, awaited_responses.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    items_sent = 0;
    results_checked = 0;
    batches_closed = 0;
    ovf_reports = 0;
    hold_req = 1'b0;
    tx_gaps_on = 1'b0;
    rx_stall_on = 1'b0;
    alpha = 31'd167772;
    beta = 25'd15099494;
    lambda = 31'd0;
    for (int k = 0; k < FEATURES; k++) begin
      wgt[k] = 0;
      vel[k] = 0;
      grad[k] = 0;
      seen[k] = 1'b0;
    end
    n_touched = 0;
    residual = 0;
    ovf = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_SAMPLE;
    in_ch.feature_index <= '0;
    in_ch.feature_value <= '0;
    in_ch.label <= 1'b0;
    in_ch.score <= '0;
    in_ch.batch_len <= 11'd1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_LEARN_RATE;
    cfg_ch.data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: unit step, full momentum, a little weight decay.
    set_regs(32'h01000000, 32'h01000000, 32'h00100000);
    tx_gaps_on = 1'b1;
    rx_stall_on = 1'b1;
    for (int k = 0; k < N_DIR; k++)
      send_txn(dir_rows[k].t, dir_rows[k].typed, dir_rows[k].r);
    drain();

    // Power-on defaults, no decay.
    set_regs(32'd167772, 32'd15099494, 32'd0);
    random_phase(170);
    drain();

    // Extremes: largest step and decay, no momentum.
    set_regs(32'h7FFFFFFF, 32'd0, 32'h7FFFFFFF);
    random_phase(170);
    drain();

    set_regs($urandom_range(0, 32'h02000000), $urandom_range(0, 32'h01000000),
             $urandom_range(0, 32'h00400000));
    overflow_batch();
    drain();

    // Upper bits beyond each register width must be dropped.
    set_regs({1'b1, 31'($urandom_range(0, 32'h04000000))},
             {7'h7F, 25'($urandom_range(0, 32'h01000000))},
             {1'b1, 31'($urandom_range(0, 32'h00200000))});
    write_reg(CFG_SPARE, $urandom);
    random_phase(60);
    hold_req = 1'b1;
    tx_gaps_on = 1'b0;
    repeat (12) send_pred(noise_txn());
    random_phase(100);
    drain();

    $display("covered %0d transactions, %0d results checked, %0d batches closed",
             items_sent, results_checked, batches_closed);
    $display("touched-list overflow reported %0d time(s), %0d mismatch(es)",
             ovf_reports, mismatches);
    if (mismatches == 0 && awaited_responses.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/slmu_pkg.sv
hdl/slmu_ifs.sv
hdl/slmu_front.sv
hdl/slmu_div.sv
hdl/slmu_back.sv
hdl/sparse_lr_momentum_update_unit.sv
tb/sv/tb_sparse_lr_momentum_update_unit.sv
